[hw/rtl/fdr_pkg.sv]
// shared constants for the fresnel dielectric reflectance pipeline
package fdr_pkg;

  localparam int unsigned ONE_Q14 = 16384;
  localparam int unsigned ONE_Q12 = 4096;
  localparam int unsigned ONE_Q15 = 32768;

  // radicand and root widths of the square root unit
  localparam int unsigned X_W    = 60;
  localparam int unsigned ROOT_W = 30;

  // operand widths of the two ratio dividers
  localparam int unsigned PAR_W  = 47;
  localparam int unsigned PERP_W = 31;

  // ratio width in q16, up to and including 1.0
  localparam int unsigned Q_W = 17;

endpackage

[hw/rtl/fdr_sqrt.sv]
// pipelined integer square root, one root bit per stage
module fdr_sqrt
  import fdr_pkg::*;
#(
  parameter int unsigned XW     = X_W,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  logic [XW-1:0]       x_in,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                vld_out,
  output logic [XW/2-1:0]     root_out,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int unsigned RW    = XW / 2;
  localparam int unsigned REM_W = RW + 3;

  logic              vld_r  [0:RW];
  logic [XW-1:0]     x_r    [0:RW];
  logic [RW-1:0]     root_r [0:RW];
  logic [REM_W-1:0]  rem_r  [0:RW];
  logic [SIDE_W-1:0] side_r [0:RW];

  // stage zero is the input itself
  always_comb begin
    vld_r[0]  = vld_in;
    x_r[0]    = x_in;
    root_r[0] = '0;
    rem_r[0]  = '0;
    side_r[0] = side_in;
  end

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_r[i][REM_W-3:0], x_r[i][XW-1:XW-2]};
      trial  = {1'b0, root_r[i], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        x_r[i+1]    <= {x_r[i][XW-3:0], 2'b00};
        root_r[i+1] <= {root_r[i][RW-2:0], take};
        rem_r[i+1]  <= take ? rem_sh - trial : rem_sh;
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign vld_out  = vld_r[RW];
  assign root_out = root_r[RW];
  assign side_out = side_r[RW];

endmodule

[hw/rtl/fdr_div.sv]
// pipelined |p-q|/(p+q) in q16 rounded half up, one quotient bit per stage
module fdr_div
  import fdr_pkg::*;
#(
  parameter int unsigned W      = PAR_W,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  logic [W-1:0]      p_in,
  input  logic [W-1:0]      q_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vld_out,
  output logic [Q_W-1:0]    ratio_out,
  output logic [SIDE_W-1:0] side_out
);

  localparam int unsigned DW = W + Q_W;

  logic              vld_r  [0:Q_W];
  logic [DW-1:0]     rem_r  [0:Q_W];
  logic [W:0]        den_r  [0:Q_W];
  logic [Q_W-1:0]    quo_r  [0:Q_W];
  logic              zero_r [0:Q_W];
  logic [SIDE_W-1:0] side_r [0:Q_W];

  logic [W-1:0] num;
  logic [W:0]   den;

  // set up numerator with rounding term and denominator
  always_comb begin
    num = (p_in >= q_in) ? p_in - q_in : q_in - p_in;
    den = {1'b0, p_in} + {1'b0, q_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
    end
    if (en) begin
      rem_r[0]  <= {1'b0, num, 16'b0} + DW'(den >> 1);
      den_r[0]  <= den;
      quo_r[0]  <= '0;
      zero_r[0] <= den == '0;
      side_r[0] <= side_in;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DW-1:0] dsh;
    logic          take;

    // restoring step for quotient bit Q_W-1-i
    always_comb begin
      dsh  = DW'(den_r[i]) << (Q_W - 1 - i);
      take = rem_r[i] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        rem_r[i+1]  <= take ? rem_r[i] - dsh : rem_r[i];
        den_r[i+1]  <= den_r[i];
        quo_r[i+1]  <= {quo_r[i][Q_W-2:0], take};
        zero_r[i+1] <= zero_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  // zero denominator counts as zero, clamp at 1.0
  always_comb begin
    if (zero_r[Q_W]) begin
      ratio_out = '0;
    end else if (quo_r[Q_W] > Q_W'(65536)) begin
      ratio_out = Q_W'(65536);
    end else begin
      ratio_out = quo_r[Q_W];
    end
  end

  assign vld_out  = vld_r[Q_W];
  assign side_out = side_r[Q_W];

endmodule

[hw/rtl/fresnel_dielectric_reflectance.sv]
// top level of the unpolarized dielectric fresnel reflectance pipeline
//
//   channel | ports                                   | direction
//   in      | in_valid in_ready in_cos_incident       | into block
//           | in_rel_index                            |
//   out     | out_valid out_ready out_reflectance     | out of block
//           | out_total_internal                      |
//
// one transaction enters per cycle while the pipeline advances; the path runs
// through the 30-stage square root and the two 18-stage ratio dividers.
// rst_n is synchronous and clears only the valid bits.
// the whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
module fresnel_dielectric_reflectance
  import fdr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_cos_incident,
  input  logic [15:0]        in_rel_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_reflectance,
  output logic               out_total_internal
);

  localparam int unsigned SIDE_W = 1 + PAR_W + 16 + PERP_W;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: clamp, pick side of the interface
  logic signed [15:0] c_cl;
  logic               neg;
  logic [14:0]        cc;
  logic [15:0]        idx;
  logic               vld1_r;
  logic [15:0]        n1_r, d1_r;
  logic [14:0]        c1_r;

  always_comb begin
    if (in_cos_incident > 16'sd16384) begin
      c_cl = 16'sd16384;
    end else if (in_cos_incident < -16'sd16384) begin
      c_cl = -16'sd16384;
    end else begin
      c_cl = in_cos_incident;
    end
    neg = c_cl < 16'sd0;
    cc  = neg ? 15'(-c_cl) : 15'(c_cl);
    idx = (in_rel_index == '0) ? 16'd1 : in_rel_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
    end
    if (adv) begin
      n1_r <= neg ? 16'(ONE_Q12) : idx;
      d1_r <= neg ? idx : 16'(ONE_Q12);
      c1_r <= cc;
    end
  end

  // stage 2: squares
  logic        vld2_r;
  logic [28:0] cc2_r;
  logic [31:0] n2_r, d2_r;
  logic [15:0] d2v_r;
  logic [14:0] c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
    if (adv) begin
      cc2_r <= 29'(c1_r) * 29'(c1_r);
      n2_r  <= 32'(n1_r) * 32'(n1_r);
      d2_r  <= 32'(d1_r) * 32'(d1_r);
      d2v_r <= d1_r;
      c2_r  <= c1_r;
    end
  end

  // stage 3: sin squared times d squared, and the ratio products
  logic        vld3_r;
  logic [28:0] s2;
  logic [60:0] sd3_r;
  logic [59:0] n2s3_r;
  logic [PAR_W-1:0]  n2c3_r;
  logic [PERP_W-1:0] dc3_r;
  logic [15:0] d3_r;

  assign s2 = 29'(1 << 28) - cc2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld3_r <= vld2_r;
    end
    if (adv) begin
      sd3_r  <= 61'(s2) * 61'(d2_r);
      n2s3_r <= {n2_r, 28'b0};
      n2c3_r <= PAR_W'(n2_r) * PAR_W'(c2_r);
      dc3_r  <= PERP_W'(d2v_r) * PERP_W'(c2_r);
      d3_r   <= d2v_r;
    end
  end

  // stage 4: total internal reflection test and radicand
  logic            vld4_r;
  logic            tir;
  logic [X_W-1:0]  x4_r;
  logic [SIDE_W-1:0] side4_r;

  assign tir = sd3_r >= {1'b0, n2s3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld4_r <= vld3_r;
    end
    if (adv) begin
      x4_r    <= tir ? '0 : n2s3_r - sd3_r[59:0];
      side4_r <= {tir, n2c3_r, d3_r, dc3_r};
    end
  end

  // square root of the radicand
  logic              vld_s;
  logic [ROOT_W-1:0] root_s;
  logic [SIDE_W-1:0] side_s;

  fdr_sqrt #(
    .XW     (X_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .vld_in   (vld4_r),
    .x_in     (x4_r),
    .side_in  (side4_r),
    .vld_out  (vld_s),
    .root_out (root_s),
    .side_out (side_s)
  );

  // stage 5: d times root for the parallel ratio
  logic              vld5_r, tir5_r;
  logic [PAR_W-1:0]  ppar5_r, qpar5_r;
  logic [PERP_W-1:0] pperp5_r, qperp5_r;
  logic [15:0]       d_s;

  assign d_s = side_s[PERP_W +: 16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (adv) begin
      vld5_r <= vld_s;
    end
    if (adv) begin
      tir5_r   <= side_s[SIDE_W-1];
      ppar5_r  <= side_s[PERP_W+16 +: PAR_W];
      qpar5_r  <= PAR_W'(d_s) * PAR_W'(root_s);
      pperp5_r <= side_s[PERP_W-1:0];
      qperp5_r <= PERP_W'(root_s);
    end
  end

  // the two amplitude ratios
  logic           vld_par, vld_perp, tir_par, tir_perp;
  logic [Q_W-1:0] r_par, r_perp;

  fdr_div #(
    .W      (PAR_W),
    .SIDE_W (1)
  ) u_div_par (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .vld_in    (vld5_r),
    .p_in      (ppar5_r),
    .q_in      (qpar5_r),
    .side_in   (tir5_r),
    .vld_out   (vld_par),
    .ratio_out (r_par),
    .side_out  (tir_par)
  );

  fdr_div #(
    .W      (PERP_W),
    .SIDE_W (1)
  ) u_div_perp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .vld_in    (vld5_r),
    .p_in      (pperp5_r),
    .q_in      (qperp5_r),
    .side_in   (tir5_r),
    .vld_out   (vld_perp),
    .ratio_out (r_perp),
    .side_out  (tir_perp)
  );

  // output stage: mean of squares, round, saturate
  logic [34:0] sum;
  logic [16:0] refl;
  logic        out_valid_r, out_ti_r;
  logic [15:0] out_refl_r;

  always_comb begin
    sum  = 35'(r_par) * 35'(r_par) + 35'(r_perp) * 35'(r_perp);
    refl = 17'((sum + 35'(1 << 17)) >> 18);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_par;
    end
    if (adv) begin
      out_ti_r <= tir_par;
      if (tir_par || refl > 17'(ONE_Q15)) begin
        out_refl_r <= 16'(ONE_Q15);
      end else begin
        out_refl_r <= refl[15:0];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reflectance    = out_refl_r;
  assign out_total_internal = out_ti_r;

  // checks
  a_ti_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_internal |-> out_reflectance == 16'(ONE_Q15))
    else $error("total internal reflection without full reflectance");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= 16'(ONE_Q15))
    else $error("reflectance above one");

  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    vld_par == vld_perp)
    else $error("ratio dividers out of step");

  a_tir_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    vld_par |-> tir_par == tir_perp)
    else $error("ratio dividers disagree on total internal reflection");

endmodule

[tb/fresnel_dielectric_reflectance_tb.sv]
// self-checking testbench for the fresnel dielectric reflectance pipeline
module fresnel_dielectric_reflectance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] cos_incident;
    logic [15:0]        rel_index;
  } shade_sample_t;

  typedef struct packed {
    logic [15:0] reflectance;
    logic        total_internal;
  } fresnel_result_t;

  localparam int unsigned LATENCY      = 54;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned N_RANDOM     = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_cos_incident;
  logic [15:0]        in_rel_index;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        out_reflectance;
  logic               out_total_internal;

  shade_sample_t   pending_samples[$];
  fresnel_result_t expected_reflectances[$];
  int unsigned     mismatch_count;
  int unsigned     cycle_count;
  bit              quiet_phase;    // no random idling
  bit              sender_paused;  // sender waits for drain
  bit              hold_receiver;  // request for a long receiver hold
  int unsigned     hold_left;

  fresnel_dielectric_reflectance dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cos_incident    (in_cos_incident),
    .in_rel_index       (in_rel_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reflectance    (out_reflectance),
    .out_total_internal (out_total_internal)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // bitwise integer square root, floor
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // |p - q| / (p + q) in q16, rounded half up, capped at one
  function automatic logic [63:0] amplitude_q16(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] r;
    num = (p >= q) ? p - q : q - p;
    den = p + q;
    if (den == 0) return 64'd0;
    r = ((num << 16) + (den >> 1)) / den;
    if (r > 64'd65536) r = 64'd65536;
    return r;
  endfunction

  // expected reflectance of one sample
  function automatic fresnel_result_t predict_reflectance(input shade_sample_t smp);
    fresnel_result_t res;
    int          c;
    logic [63:0] idx, n, d, cc, s2, x, s, rpar, rperp, sum, refl;
    c = smp.cos_incident;
    idx = {48'd0, smp.rel_index};
    if (c > int'(fdr_pkg::ONE_Q14)) c = int'(fdr_pkg::ONE_Q14);
    if (c < -int'(fdr_pkg::ONE_Q14)) c = -int'(fdr_pkg::ONE_Q14);
    if (idx == 0) idx = 64'd1;
    // negative cosine: ray from the other side
    if (c < 0) begin
      n = 64'(fdr_pkg::ONE_Q12);
      d = idx;
      cc = 64'(-c);
    end else begin
      n = idx;
      d = 64'(fdr_pkg::ONE_Q12);
      cc = 64'(c);
    end
    s2 = (64'd1 << 28) - cc * cc;
    if (s2 * d * d >= ((n * n) << 28)) begin
      res.reflectance = 16'(fdr_pkg::ONE_Q15);
      res.total_internal = 1'b1;
      return res;
    end
    x = ((n * n) << 28) - s2 * d * d;
    s = floor_sqrt(x);
    rpar = amplitude_q16(n * n * cc, d * s);
    rperp = amplitude_q16(d * cc, s);
    sum = rpar * rpar + rperp * rperp;
    refl = (sum + (64'd1 << 17)) >> 18;
    if (refl > 64'(fdr_pkg::ONE_Q15)) refl = 64'(fdr_pkg::ONE_Q15);
    res.reflectance = refl[15:0];
    res.total_internal = 1'b0;
    return res;
  endfunction

  function automatic shade_sample_t make_sample(input int c, input int unsigned idx);
    shade_sample_t smp;
    smp.cos_incident = 16'(c);
    smp.rel_index = 16'(idx);
    return smp;
  endfunction

  // random sample, mostly physical cosines and indexes, some raw codes
  function automatic shade_sample_t random_sample();
    shade_sample_t smp;
    int unsigned   pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      smp.cos_incident = 16'($urandom_range(0, 32768) - 16384);
      smp.rel_index = 16'($urandom_range(1024, 12288));
    end else if (pick < 9) begin
      smp.cos_incident = 16'($urandom_range(0, 32768) - 16384);
      smp.rel_index = 16'($urandom_range(1024, 65535));
    end else begin
      smp.cos_incident = 16'($urandom);
      smp.rel_index = 16'($urandom);
    end
    return smp;
  endfunction

  // stimulus plan: directed corners, then random samples
  initial begin
    quiet_phase = 1'b0;
    sender_paused = 1'b0;
    hold_receiver = 1'b0;
    pending_samples.push_back(make_sample(16384, 4096));
    pending_samples.push_back(make_sample(16384, 6144));
    pending_samples.push_back(make_sample(-16384, 6144));
    pending_samples.push_back(make_sample(0, 6144));
    pending_samples.push_back(make_sample(0, 2048));
    pending_samples.push_back(make_sample(-4000, 6144));
    pending_samples.push_back(make_sample(8000, 2048));
    pending_samples.push_back(make_sample(32767, 1024));
    pending_samples.push_back(make_sample(-32768, 65535));
    pending_samples.push_back(make_sample(20000, 0));
    pending_samples.push_back(make_sample(-20000, 0));
    pending_samples.push_back(make_sample(1, 65535));
    pending_samples.push_back(make_sample(-1, 65535));
    pending_samples.push_back(make_sample(-1, 1024));
    pending_samples.push_back(make_sample(12000, 1));
    pending_samples.push_back(make_sample(-12000, 1));
    pending_samples.push_back(make_sample(16383, 4097));
    pending_samples.push_back(make_sample(-16383, 4095));
    pending_samples.push_back(make_sample(-1, 16'hAAAA));
    pending_samples.push_back(make_sample(21845, 16'h5555));
    for (int i = 0; i < N_RANDOM; i++) pending_samples.push_back(random_sample());
  end

  // reset, pressure phases, and end of run
  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // stretch with no idling
    wait (pending_samples.size() < 1700);
    quiet_phase = 1'b1;
    wait (pending_samples.size() < 1400);
    quiet_phase = 1'b0;
    // receiver holds off while sender keeps offering
    hold_receiver = 1'b1;
    wait (pending_samples.size() < 1000);
    // sender waits for every result
    @(posedge clk);
    sender_paused = 1'b1;
    wait (expected_reflectances.size() == 0);
    @(posedge clk);
    sender_paused = 1'b0;
    wait (pending_samples.size() == 0);
    wait (!in_valid);
    wait (expected_reflectances.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_reflectances.size() == 0)
      $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // driver: offers pending samples, valid held until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_reflectances.push_back(
          predict_reflectance({in_cos_incident, in_rel_index}));
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && !sender_paused
            && (quiet_phase || $urandom_range(0, 99) >= 37)) begin
          shade_sample_t smp;
          smp = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_cos_incident <= smp.cos_incident;
          in_rel_index <= smp.rel_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver readiness, with one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_receiver && hold_left == 0) begin
      hold_receiver <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      hold_left <= 0;
      out_ready <= quiet_phase || ($urandom_range(0, 99) >= 37);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reflectances.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("unexpected result: reflectance %0d tir %0b",
                   out_reflectance, out_total_internal);
      end else begin
        fresnel_result_t want;
        want = expected_reflectances.pop_front();
        if (want.reflectance !== out_reflectance
            || want.total_internal !== out_total_internal) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: reflectance exp %0d got %0d, tir exp %0b got %0b",
                     want.reflectance, out_reflectance,
                     want.total_internal, out_total_internal);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_cos_incident = '0;
    in_rel_index = '0;
    hold_left = 0;
  end

endmodule

[filelist.f]
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_sqrt.sv
hw/rtl/fdr_div.sv
hw/rtl/fresnel_dielectric_reflectance.sv
tb/fresnel_dielectric_reflectance_tb.sv
